FILE: design/msd_pkg.sv
// Shared types, constants and the letter lookup table for the Morse sample decoder.
package msd_pkg;

  localparam int SAMPLE_W = 12;
  localparam int DOT_W    = 8;
  localparam int CHAR_W   = 7;
  localparam int RUN_W    = 16;
  localparam int MULT_W   = 13;
  localparam int LOOK_LEN_W  = 4;
  localparam int LOOK_BITS_W = 15;
  localparam int CODES    = 36;

  localparam logic [RUN_W-1:0]    RUN_MAX          = 16'hFFFF;
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET  = 12'd200;
  localparam logic [DOT_W-1:0]    DOT_RESET        = 8'd1;
  localparam logic [CHAR_W-1:0]   CHAR_SPACE       = 7'h20;
  localparam logic [CHAR_W-1:0]   CHAR_UNKNOWN     = 7'h3F;
  localparam logic [CHAR_W-1:0]   CHAR_NONE        = 7'h00;

  typedef enum logic {
    CFG_ON_THRESHOLD = 1'b0,
    CFG_DOT_SAMPLES  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_message;
    logic              last_of_run;
  } result_t;

  typedef struct packed {
    logic [3:0]        len;
    logic [4:0]        bits;
    logic [CHAR_W-1:0] ch;
  } code_entry_t;

  // First symbol is the most significant of len bits; a dash is a one.
  localparam code_entry_t CODE_TABLE [CODES] = '{
    '{4'd2, 5'd1,  7'h41}, '{4'd4, 5'd8,  7'h42}, '{4'd4, 5'd10, 7'h43},
    '{4'd3, 5'd4,  7'h44}, '{4'd1, 5'd0,  7'h45}, '{4'd4, 5'd2,  7'h46},
    '{4'd3, 5'd6,  7'h47}, '{4'd4, 5'd0,  7'h48}, '{4'd2, 5'd0,  7'h49},
    '{4'd4, 5'd7,  7'h4A}, '{4'd3, 5'd5,  7'h4B}, '{4'd4, 5'd4,  7'h4C},
    '{4'd2, 5'd3,  7'h4D}, '{4'd2, 5'd2,  7'h4E}, '{4'd3, 5'd7,  7'h4F},
    '{4'd4, 5'd6,  7'h50}, '{4'd4, 5'd13, 7'h51}, '{4'd3, 5'd2,  7'h52},
    '{4'd3, 5'd0,  7'h53}, '{4'd1, 5'd1,  7'h54}, '{4'd3, 5'd1,  7'h55},
    '{4'd4, 5'd1,  7'h56}, '{4'd3, 5'd3,  7'h57}, '{4'd4, 5'd9,  7'h58},
    '{4'd4, 5'd11, 7'h59}, '{4'd4, 5'd12, 7'h5A}, '{4'd5, 5'd31, 7'h30},
    '{4'd5, 5'd15, 7'h31}, '{4'd5, 5'd7,  7'h32}, '{4'd5, 5'd3,  7'h33},
    '{4'd5, 5'd1,  7'h34}, '{4'd5, 5'd0,  7'h35}, '{4'd5, 5'd16, 7'h36},
    '{4'd5, 5'd24, 7'h37}, '{4'd5, 5'd28, 7'h38}, '{4'd5, 5'd30, 7'h39}
  };

  function automatic logic [CHAR_W-1:0] lookup_letter(
    input logic [LOOK_LEN_W-1:0]  len,
    input logic [LOOK_BITS_W-1:0] bits
  );
    logic [CHAR_W-1:0] ch;
    logic              found;
    ch    = CHAR_UNKNOWN;
    found = 1'b0;
    for (int i = 0; i < CODES; i++) begin
      if (!found && CODE_TABLE[i].len == len &&
          {10'd0, CODE_TABLE[i].bits} == bits) begin
        ch    = CODE_TABLE[i].ch;
        found = 1'b1;
      end
    end
    return ch;
  endfunction

endpackage

FILE: design/msd_decode.sv
// Run-length tracking, symbol assembly and character generation for one sample.
module msd_decode #(
  parameter int PATTERN_SLOTS = 16,
  parameter int MSG_CAP       = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [msd_pkg::SAMPLE_W-1:0]  sample,
  input  logic [msd_pkg::SAMPLE_W-1:0]  on_threshold,
  input  logic [msd_pkg::DOT_W-1:0]     dot_samples,
  input  logic                          fire,
  output logic [1:0]                    res_n,
  output msd_pkg::result_t              res0,
  output msd_pkg::result_t              res1
);

  localparam int PW = $clog2(PATTERN_SLOTS);
  localparam int BW = PATTERN_SLOTS - 1;
  localparam int MW = $clog2(MSG_CAP);
  localparam logic [PW:0] SLOTS = (PW + 1)'(PATTERN_SLOTS);
  localparam logic [MW:0] CAP   = (MW + 1)'(MSG_CAP);

  logic                       prev_on_r, prev_on_nxt;
  logic [msd_pkg::RUN_W-1:0]  on_run_r, on_run_nxt;
  logic [msd_pkg::RUN_W-1:0]  off_run_r, off_run_nxt;
  logic [PW-1:0]              plen_r, plen_nxt;
  logic [BW-1:0]              pbits_r, pbits_nxt;
  logic [MW-1:0]              msg_len_r, msg_len_nxt;
  logic                       last_space_r, last_space_nxt;
  logic                       flush_done_r, flush_done_nxt;

  logic                       is_on;
  logic [msd_pkg::DOT_W-1:0]  t;
  logic [msd_pkg::MULT_W-1:0] t1, t2, t3, t7, t20, t21;
  logic [msd_pkg::RUN_W-1:0]  off_inc;
  logic [msd_pkg::CHAR_W-1:0] letter;
  logic                       letter_emit;
  logic [MW-1:0]              msg_a;
  logic                       space_a;
  logic                       room_after;
  logic                       letter_gap, close_word, symbol_add, flush_hit;
  logic                       first_valid, second_valid;
  msd_pkg::result_t           first_res, second_res;

  assign is_on = sample > on_threshold;
  assign t     = (dot_samples == '0) ? msd_pkg::DOT_W'(1) : dot_samples;
  assign t1    = {5'd0, t};
  assign t2    = t1 << 1;
  assign t3    = t2 + t1;
  assign t7    = (t1 << 3) - t1;
  assign t20   = (t1 << 4) + (t1 << 2);
  assign t21   = t20 + t1;

  assign off_inc = (off_run_r != msd_pkg::RUN_MAX) ? off_run_r + 1'b1 : off_run_r;

  assign letter = msd_pkg::lookup_letter(msd_pkg::LOOK_LEN_W'(plen_r),
                                         msd_pkg::LOOK_BITS_W'(pbits_r));

  // Closing a letter: what the message state looks like after the letter beat.
  assign letter_emit = (plen_r != '0) && (({1'b0, msg_len_r} + 1'b1) < CAP);
  assign msg_a       = letter_emit ? msg_len_r + 1'b1 : msg_len_r;
  assign space_a     = letter_emit ? 1'b0 : last_space_r;
  assign room_after  = ({1'b0, msg_a} + 1'b1) < CAP;

  always_comb begin
    prev_on_nxt    = is_on;
    on_run_nxt     = on_run_r;
    off_run_nxt    = off_run_r;
    plen_nxt       = plen_r;
    pbits_nxt      = pbits_r;
    msg_len_nxt    = msg_len_r;
    last_space_nxt = last_space_r;
    flush_done_nxt = flush_done_r;
    letter_gap     = 1'b0;
    close_word     = 1'b0;
    flush_hit      = 1'b0;
    symbol_add     = 1'b0;

    if (prev_on_r && !is_on) begin
      symbol_add = (on_run_r == {3'd0, t1}) || (on_run_r == {3'd0, t2});
      if (symbol_add && (({1'b0, plen_r} + 1'b1) < SLOTS)) begin
        pbits_nxt = {pbits_r[BW-2:0], (on_run_r == {3'd0, t2})};
        plen_nxt  = plen_r + 1'b1;
      end
      on_run_nxt  = '0;
      off_run_nxt = msd_pkg::RUN_W'(1);
    end else if (!prev_on_r && is_on) begin
      letter_gap     = (off_run_r == {3'd0, t3});
      close_word     = (off_run_r >= {3'd0, t7}) && (off_run_r <= {3'd0, t20});
      off_run_nxt    = '0;
      on_run_nxt     = msd_pkg::RUN_W'(1);
      flush_done_nxt = 1'b0;
    end else if (is_on) begin
      if (on_run_r != msd_pkg::RUN_MAX) begin
        on_run_nxt = on_run_r + 1'b1;
      end
    end else begin
      off_run_nxt = off_inc;
      flush_hit   = (off_inc >= {3'd0, t21}) && !flush_done_r;
    end

    if (letter_gap || close_word) begin
      plen_nxt       = '0;
      pbits_nxt      = '0;
      msg_len_nxt    = msg_a;
      last_space_nxt = space_a;
    end
    if (close_word && ((msg_a == '0) || !space_a) && room_after) begin
      msg_len_nxt    = msg_a + 1'b1;
      last_space_nxt = 1'b1;
    end
    if (flush_hit) begin
      plen_nxt       = '0;
      pbits_nxt      = '0;
      msg_len_nxt    = '0;
      last_space_nxt = 1'b0;
      flush_done_nxt = 1'b1;
    end
  end

  // Result beats in order: the closed letter first, then a space or the end mark.
  assign first_valid  = (letter_gap || close_word || flush_hit) && letter_emit;
  assign second_valid = flush_hit ||
                        (close_word && ((msg_a == '0) || !space_a) && room_after);

  always_comb begin
    first_res.char_code       = letter;
    first_res.end_of_message  = 1'b0;
    first_res.last_of_run     = !second_valid;
    second_res.char_code      = flush_hit ? msd_pkg::CHAR_NONE : msd_pkg::CHAR_SPACE;
    second_res.end_of_message = flush_hit;
    second_res.last_of_run    = 1'b1;
  end

  always_comb begin
    res_n = {1'b0, first_valid} + {1'b0, second_valid};
    res0  = first_valid ? first_res : second_res;
    res1  = second_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_on_r    <= 1'b0;
      on_run_r     <= '0;
      off_run_r    <= '0;
      plen_r       <= '0;
      pbits_r      <= '0;
      msg_len_r    <= '0;
      last_space_r <= 1'b0;
      flush_done_r <= 1'b0;
    end else if (fire) begin
      prev_on_r    <= prev_on_nxt;
      on_run_r     <= on_run_nxt;
      off_run_r    <= off_run_nxt;
      plen_r       <= plen_nxt;
      pbits_r      <= pbits_nxt;
      msg_len_r    <= msg_len_nxt;
      last_space_r <= last_space_nxt;
      flush_done_r <= flush_done_nxt;
    end
  end

endmodule

FILE: design/msd_out_buf.sv
// Two-entry result buffer that takes up to two beats at once and drains one per cycle while out_ready is high.
module msd_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_n,
  input  msd_pkg::result_t push0,
  input  msd_pkg::result_t push1,
  output logic [1:0]       free,
  output logic             out_valid,
  input  logic             out_ready,
  output msd_pkg::result_t out_res
);

  msd_pkg::result_t slot_r [2];
  msd_pkg::result_t slot_nxt [2];
  logic [1:0]       cnt_r, cnt_nxt;
  logic [1:0]       cnt_after;
  logic             pop;

  assign out_valid = cnt_r != 2'd0;
  assign out_res   = slot_r[0];
  assign pop       = out_valid && out_ready;
  assign cnt_after = cnt_r - {1'b0, pop};
  assign free      = 2'd2 - cnt_after;

  always_comb begin
    slot_nxt[0] = pop ? slot_r[1] : slot_r[0];
    slot_nxt[1] = slot_r[1];
    if (cnt_after == 2'd0) begin
      if (push_n != 2'd0) begin
        slot_nxt[0] = push0;
      end
      if (push_n == 2'd2) begin
        slot_nxt[1] = push1;
      end
    end else if (cnt_after == 2'd1) begin
      if (push_n != 2'd0) begin
        slot_nxt[1] = push0;
      end
    end
    cnt_nxt = cnt_after + push_n;
  end

  always_ff @(posedge clk) begin
    slot_r[0] <= slot_nxt[0];
    slot_r[1] <= slot_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: design/morse_sample_decoder.sv
// Top level of the Morse sample decoder: input register, configuration and result buffer.
//
//   channel  direction  beat contents
//   in_      in         sample
//   out_     out        char_code, end_of_message, last_of_run
//   cfg_     in         register write (index, data), no handshake
//
// A sample beat is registered, then decoded combinationally while the next beat enters.
// A sample that yields no characters leaves room for a new beat every cycle; one that
// yields a letter plus a space or end mark pushes two beats into the two-entry result
// buffer, which drains one beat per cycle while out_ready is high.
// Reset is synchronous and clears the run counters, letter and message state.
// A stall on out_ready backs up into in_ready once the buffer cannot take a sample's results.
module morse_sample_decoder #(
  parameter int PATTERN_SLOTS = 16,
  parameter int MSG_CAP       = 512
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [msd_pkg::SAMPLE_W-1:0]      in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [msd_pkg::CHAR_W-1:0]        out_char_code,
  output logic                              out_end_of_message,
  output logic                              out_last_of_run,
  input  logic                              cfg_we,
  input  msd_pkg::cfg_index_t               cfg_index,
  input  logic [msd_pkg::SAMPLE_W-1:0]      cfg_wdata
);

  logic                         in_v_r;
  logic [msd_pkg::SAMPLE_W-1:0] sample_r;
  logic [msd_pkg::SAMPLE_W-1:0] threshold_r;
  logic [msd_pkg::DOT_W-1:0]    dot_r;
  logic [1:0]                   res_n;
  logic [1:0]                   free;
  logic                         fire;
  msd_pkg::result_t             res0, res1, out_res;

  assign fire     = in_v_r && (res_n <= free);
  assign in_ready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sample_r <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= msd_pkg::THRESHOLD_RESET;
      dot_r       <= msd_pkg::DOT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msd_pkg::CFG_ON_THRESHOLD: threshold_r <= cfg_wdata;
        msd_pkg::CFG_DOT_SAMPLES:  dot_r       <= cfg_wdata[msd_pkg::DOT_W-1:0];
        default: ;
      endcase
    end
  end

  msd_decode #(
    .PATTERN_SLOTS (PATTERN_SLOTS),
    .MSG_CAP       (MSG_CAP)
  ) u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample       (sample_r),
    .on_threshold (threshold_r),
    .dot_samples  (dot_r),
    .fire         (fire),
    .res_n        (res_n),
    .res0         (res0),
    .res1         (res1)
  );

  msd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (fire ? res_n : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_char_code      = out_res.char_code;
  assign out_end_of_message = out_res.end_of_message;
  assign out_last_of_run    = out_res.last_of_run;

endmodule
